// ----- rtl/core/positional_insert_delete_list_core_assert.svh -----
// Assertion macros for the checker file.
`ifndef POSITIONAL_INSERT_DELETE_LIST_CORE_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define PLID_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("plid assertion failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define PLID_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("plid assertion failed");

`endif

// ----- rtl/core/plid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package plid_pkg;

   localparam int DataW      = 32;
   localparam int PosW       = 9;
   localparam int KindW      = 2;
   localparam int StatusW    = 2;
   localparam int CountW     = 7;
   localparam int ReqDataW   = 48;
   localparam int RspDataW   = 48;
   localparam int DefCapacity = 64;
   localparam int FanIn      = 8;

   // operation codes carried on req_tuser
   localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
   localparam logic [KindW-1:0] KIND_ERASE  = 2'd1;
   localparam logic [KindW-1:0] KIND_READ   = 2'd2;

   // result status codes
   localparam logic [StatusW-1:0] ST_OK        = 2'd0;
   localparam logic [StatusW-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic load;   // a word was accepted this cycle
      logic ins;    // shift up and write value at pos
      logic del;    // shift down from pos
      logic rd;     // select the element at pos for the read tree
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WORK,
      S_DONE
   } state_type;

   // number of nodes on level k of an OR tree over n leaves (level 0 = leaves)
   function automatic int level_size(input int n, input int k);
      int s;
      s = n;
      for (int i = 0; i < k; i++) s = (s + FanIn - 1) / FanIn;
      return s;
   endfunction

   // registered levels needed to reduce n leaves to one node
   function automatic int tree_levels(input int n);
      int s;
      int l;
      s = n;
      l = 0;
      while (s > 1) begin
         s = (s + FanIn - 1) / FanIn;
         l++;
      end
      return (l < 1) ? 1 : l;
   endfunction

   // first slot of level k (k >= 1) in the flat node array
   function automatic int level_offset(input int n, input int k);
      int o;
      o = 0;
      for (int i = 1; i < k; i++) o += level_size(n, i);
      return o;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/plid_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plid_cell import plid_pkg::*; #(
   parameter int IDX_W = 6,
   parameter int IDX   = 0
) (
   input  wire logic             clock,
   input  wire op_type           op,
   input  wire logic [IDX_W-1:0] pos,
   input  wire logic [DataW-1:0] value,
   input  wire logic [DataW-1:0] left_data,
   input  wire logic [DataW-1:0] right_data,
   output logic      [DataW-1:0] elem_data,
   output logic      [DataW-1:0] rd_data
);

   localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

   logic [DataW-1:0] elem_ff, elem_in;
   logic [DataW-1:0] rd_ff, rd_in;

   // take the new value, the left neighbor on insert, the right one on erase
   always_comb begin
      priority if (op.ins && pos == MyIdx) begin
         elem_in = value;
      end else if (op.ins && pos < MyIdx) begin
         elem_in = left_data;
      end else if (op.del && pos <= MyIdx) begin
         elem_in = right_data;
      end else begin
         elem_in = elem_ff;
      end
   end

   // on each accepted word offer the element to the read tree when selected, else zero; else hold
   always_comb begin
      if (op.load) begin
         rd_in = (op.rd && pos == MyIdx) ? elem_ff : '0;
      end else begin
         rd_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      rd_ff   <= rd_in;
   end

   assign elem_data = elem_ff;
   assign rd_data   = rd_ff;

endmodule
`default_nettype wire

// ----- rtl/core/plid_or_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plid_or_tree import plid_pkg::*; #(
   parameter int LEAVES = DefCapacity
) (
   input  wire logic             clock,
   input  wire logic [DataW-1:0] leaf_data [LEAVES],
   output logic      [DataW-1:0] root_data
);

   localparam int Levels = tree_levels(LEAVES);
   localparam int Nodes  = level_offset(LEAVES, Levels + 1);

   logic [DataW-1:0] node_ff [Nodes];

   // each node ORs up to FanIn children of the level below
   for (genvar k = 1; k <= Levels; k++) begin : g_lvl
      localparam int Size     = level_size(LEAVES, k);
      localparam int PrevSize = level_size(LEAVES, k - 1);
      localparam int Off      = level_offset(LEAVES, k);
      localparam int PrevOff  = (k > 1) ? level_offset(LEAVES, k - 1) : 0;
      for (genvar m = 0; m < Size; m++) begin : g_node
         logic [DataW-1:0] node_in;
         always_comb begin
            node_in = '0;
            for (int j = 0; j < FanIn; j++) begin
               if (m * FanIn + j < PrevSize) begin
                  if (k == 1) begin
                     node_in = node_in | leaf_data[m * FanIn + j];
                  end else begin
                     node_in = node_in | node_ff[PrevOff + m * FanIn + j];
                  end
               end
            end
         end
         always_ff @(posedge clock) begin
            node_ff[Off + m] <= node_in;
         end
      end
   end

   assign root_data = node_ff[Nodes - 1];

endmodule
`default_nettype wire

// ----- rtl/core/positional_insert_delete_list_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells, one element
// per cell. Insert and erase each finish in one shift of the whole row. The read word
// is then gathered through a registered OR tree with fan-in 8. rsp_tvalid rises once the
// item has passed the cell registers, the tree levels and the output register. req_tready
// comes back in the cycle in which rsp_tvalid rises, so a new item is accepted only after
// the previous one has left the tree. The next item is taken even while the previous
// result is still waiting on rsp_tready. It then runs through the tree and holds in its
// last step until the output register is free. Each item gives exactly one result with
// status (ok, bad position, full) and the length after the operation. read_data is zero
// unless a read succeeds. Cell contents are undefined until written and come up unset
// after reset.
module positional_insert_delete_list_core import plid_pkg::*; #(
   parameter int CAPACITY = DefCapacity
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,   // position[8:0], value[40:9], zero pad
   input  wire logic [KindW-1:0]    req_tuser,   // kind[1:0]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [RspDataW-1:0] rsp_tdata    // status[1:0], count[8:2], read_data[40:9]
);

   localparam int IdxW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW   = $clog2(CAPACITY + 1);
   localparam int CmpW   = (CntW > 8) ? CntW : 8;
   localparam int Levels = tree_levels(CAPACITY);
   localparam int LvlW   = $clog2(Levels + 1);
   localparam logic [CntW-1:0] FullCount = CntW'(CAPACITY);
   localparam logic [LvlW-1:0] LastLvl   = LvlW'(Levels - 1);

   // unpack the request word
   logic [PosW-1:0]  req_pos;
   logic [DataW-1:0] req_value;
   assign req_pos   = req_tdata[PosW-1:0];
   assign req_value = req_tdata[PosW+DataW-1:PosW];

   state_type         state_ff, state_in;
   logic [LvlW-1:0]   lvl_ff, lvl_in;
   logic [CntW-1:0]   fill_ff, fill_in;
   logic [StatusW-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic              accept;
   logic              load_rsp;

   // range checks against the current length
   logic [CmpW-1:0] pos_mag;
   logic [CmpW-1:0] fill_ext;
   logic            pos_nonneg;
   logic            ins_in_range, idx_in_range, is_full;
   op_type          op;

   assign pos_mag      = CmpW'(req_pos[PosW-2:0]);
   assign fill_ext     = CmpW'(fill_ff);
   assign pos_nonneg   = ~req_pos[PosW-1];
   assign ins_in_range = pos_nonneg && (pos_mag <= fill_ext);
   assign idx_in_range = pos_nonneg && (pos_mag < fill_ext);
   assign is_full      = (fill_ff == FullCount);

   // decode the accepted word into a cell command, status and new length
   always_comb begin
      op        = '0;
      op.load   = accept;
      status_in = status_ff;
      fill_in   = fill_ff;
      if (accept) begin
         status_in = ST_BAD_INDEX;
         unique case (req_tuser)
            KIND_INSERT: begin
               if (ins_in_range) begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     op.ins    = 1'b1;
                     fill_in   = fill_ff + CntW'(1);
                     status_in = ST_OK;
                  end
               end
            end
            KIND_ERASE: begin
               if (idx_in_range) begin
                  op.del    = 1'b1;
                  fill_in   = fill_ff - CntW'(1);
                  status_in = ST_OK;
               end
            end
            KIND_READ: begin
               if (idx_in_range) begin
                  op.rd     = 1'b1;
                  status_in = ST_OK;
               end
            end
            default: begin
               status_in = ST_BAD_INDEX;
            end
         endcase
      end
   end

   // row of cells, each wired to its two neighbors
   logic [DataW-1:0] elem_data [CAPACITY];
   logic [DataW-1:0] rd_data   [CAPACITY];
   logic [IdxW-1:0]  cell_pos;
   assign cell_pos = pos_mag[IdxW-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int Left  = (i == 0) ? 0 : i - 1;
      localparam int Right = (i == CAPACITY - 1) ? i : i + 1;
      plid_cell #(
         .IDX_W (IdxW),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .pos        (cell_pos),
         .value      (req_value),
         .left_data  (elem_data[Left]),
         .right_data (elem_data[Right]),
         .elem_data  (elem_data[i]),
         .rd_data    (rd_data[i])
      );
   end

   // gather the selected element
   logic [DataW-1:0] root_data;
   plid_or_tree #(
      .LEAVES (CAPACITY)
   ) u_tree (
      .clock     (clock),
      .leaf_data (rd_data),
      .root_data (root_data)
   );

   // sequence one item through the tree, then hand it to the output register
   always_comb begin
      state_in   = state_ff;
      lvl_in     = lvl_ff;
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_WORK;
               lvl_in   = '0;
            end
         end
         S_WORK: begin
            lvl_in = lvl_ff + LvlW'(1);
            if (lvl_ff == LastLvl) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // hold the result until the sink takes it
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RspDataW'({root_data, CountW'(fill_ff), status_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/plid_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "positional_insert_delete_list_core_assert.svh"
module plid_checker import plid_pkg::*; #(
   parameter int CAPACITY = DefCapacity
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic [ReqDataW-1:0] req_tdata,
   input wire logic [KindW-1:0]    req_tuser,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RspDataW-1:0] rsp_tdata
);

   localparam int CntLimit = (CAPACITY > 127) ? 127 : CAPACITY;

   logic [StatusW-1:0] rsp_status;
   logic [CountW-1:0]  rsp_count;
   logic [DataW-1:0]   rsp_read;
   assign rsp_status = rsp_tdata[StatusW-1:0];
   assign rsp_count  = rsp_tdata[StatusW+CountW-1:StatusW];
   assign rsp_read   = rsp_tdata[StatusW+CountW+DataW-1:StatusW+CountW];

   // a stalled result word holds
   `PLID_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // one item at a time: no second word right behind an accepted one
   `PLID_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)
   // only defined status codes, and a length within capacity
   `PLID_ASSERT_NOW(a_status_code, rsp_tvalid, rsp_status <= ST_FULL)
   `PLID_ASSERT_NOW(a_count_range, rsp_tvalid && (CAPACITY < 128), 32'(rsp_count) <= CntLimit)
   // a failed item returns no data
   `PLID_ASSERT_NOW(a_read_zero, rsp_tvalid && rsp_status != ST_OK, rsp_read == '0)

endmodule

bind positional_insert_delete_list_core plid_checker #(.CAPACITY(CAPACITY)) u_plid_checker (.*);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench import plid_pkg::*;;

   localparam int Capacity   = DefCapacity;
   localparam int HoldCycles = 300;
   localparam int PhaseItems = 190;
   localparam int PhaseCount = 5;
   localparam int DrainWait  = 20;
   // kind code that the block leaves unused
   localparam logic [KindW-1:0] KindUnused = 2'd3;

   typedef struct packed {
      logic [StatusW-1:0]      status;
      logic [CountW-1:0]       count;
      logic signed [DataW-1:0] read_data;
   } list_outcome_type;

   // Shadow copy of the list: predicts one outcome per accepted word.
   class list_mirror_type;
      logic signed [DataW-1:0] cells [Capacity];
      int                      fill_level;
      list_outcome_type        outcome_q [$];
      int                      errors;

      function new();
         fill_level = 0;
         errors     = 0;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      // Apply one accepted request word and queue the outcome it must give.
      function void note_request(input logic [KindW-1:0] kind,
                                 input logic signed [PosW-1:0] pos,
                                 input logic signed [DataW-1:0] value);
         list_outcome_type o;
         int p;
         p           = int'(pos);
         o.status    = ST_BAD_INDEX;
         o.read_data = '0;
         unique case (kind)
            KIND_INSERT: begin
               if (p >= 0 && p <= fill_level) begin
                  if (fill_level >= Capacity) begin
                     o.status = ST_FULL;
                  end else begin
                     for (int i = fill_level; i > p; i--) cells[i] = cells[i-1];
                     cells[p] = value;
                     fill_level++;
                     o.status = ST_OK;
                  end
               end
            end
            KIND_ERASE: begin
               if (p >= 0 && p < fill_level) begin
                  for (int i = p + 1; i < fill_level; i++) cells[i-1] = cells[i];
                  fill_level--;
                  o.status = ST_OK;
               end
            end
            KIND_READ: begin
               if (p >= 0 && p < fill_level) begin
                  o.read_data = cells[p];
                  o.status    = ST_OK;
               end
            end
            default: ;
         endcase
         o.count = CountW'(fill_level);
         outcome_q.push_back(o);
      endfunction

      // Compare one accepted result word with the oldest queued outcome.
      function void check_response(input logic [RspDataW-1:0] word);
         list_outcome_type o;
         logic [StatusW-1:0]      got_status;
         logic [CountW-1:0]       got_count;
         logic signed [DataW-1:0] got_data;
         got_status = word[StatusW-1:0];
         got_count  = word[StatusW +: CountW];
         got_data   = word[StatusW+CountW +: DataW];
         if (outcome_q.size() == 0) begin
            $error("result word %h with no request outstanding", word);
            errors++;
            return;
         end
         o = outcome_q.pop_front();
         if (got_status !== o.status) begin
            $error("status: expected %0d, actual %0d", o.status, got_status);
            errors++;
         end
         if (got_count !== o.count) begin
            $error("count: expected %0d, actual %0d", o.count, got_count);
            errors++;
         end
         if (got_data !== o.read_data) begin
            $error("read_data: expected %0d, actual %0d", o.read_data, got_data);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;   // position[8:0], value[40:9], zero pad
   logic [KindW-1:0]    req_tuser  = '0;   // kind[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;         // status[1:0], count[8:2], read_data[40:9]

   list_mirror_type mirror;
   int              burst_left    = 0;
   bit              long_hold_due = 1'b0;

   positional_insert_delete_list_core #(
      .CAPACITY(Capacity)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one word until taken, then idle for a random gap at the end of a burst.
   task automatic send_word(input logic [KindW-1:0] kind,
                            input logic signed [PosW-1:0] pos,
                            input logic signed [DataW-1:0] value);
      bit taken;
      int gap;
      taken      = 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataW'({value, pos});
      req_tuser  <= kind;
      while (!taken) begin
         @(negedge clock);
         if (req_tready) begin
            taken = 1'b1;
            mirror.note_request(kind, pos, value);
         end
         @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Build one random word, biased to grow or shrink the list.
   task automatic random_item(input bit grow);
      int fill;
      int r;
      int q;
      int p;
      logic [KindW-1:0]        k;
      logic signed [DataW-1:0] v;
      fill = mirror.fill_level;
      r    = $urandom_range(0, 99);
      if (r < 4) k = KindUnused;
      else if (r < (grow ? 72 : 20)) k = KIND_INSERT;
      else if (r < 75) k = KIND_ERASE;
      else k = KIND_READ;
      // mostly legal positions, some on the boundary, some raw noise
      q = $urandom_range(0, 9);
      if (q == 0) begin
         p = $urandom_range(0, 2**PosW - 1);
      end else if (q == 1) begin
         p = (k == KIND_INSERT) ? fill + 1 : fill;
      end else if (k == KIND_INSERT) begin
         p = $urandom_range(0, fill);
      end else begin
         p = (fill > 0) ? $urandom_range(0, fill - 1) : 0;
      end
      case ($urandom_range(0, 9))
         0:       v = 32'sh8000_0000;
         1:       v = 32'sh7fff_ffff;
         2:       v = '0;
         3:       v = -32'sd1;
         default: v = $urandom;
      endcase
      send_word(k, PosW'(p), v);
   endtask

   // Receiver: runs of ready, runs of stall, random toggling, one long hold.
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            case ($urandom_range(0, 3))
               0, 3: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(1, 40)) @(posedge clock);
               end
               1: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(1, 12)) @(posedge clock);
               end
               default: begin
                  repeat ($urandom_range(2, 16)) begin
                     rsp_tready <= 1'($urandom_range(0, 1));
                     @(posedge clock);
                  end
               end
            endcase
         end
      end
   end

   // Check every result word taken at the coming edge.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) mirror.check_response(rsp_tdata);
   end

   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      mirror = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list: nothing to read or erase, insert only at zero
      send_word(KIND_READ, 9'sd0, 32'sd0);
      send_word(KIND_ERASE, 9'sd0, 32'sd0);
      send_word(KIND_INSERT, -9'sd1, 32'sd7);
      send_word(KIND_INSERT, 9'sd1, 32'sd7);
      // fill at the front, the end and the middle with extreme values
      send_word(KIND_INSERT, 9'sd0, 32'sh7fff_ffff);
      send_word(KIND_INSERT, 9'sd0, 32'sh8000_0000);
      send_word(KIND_INSERT, 9'sd2, -32'sd1);
      send_word(KIND_INSERT, 9'sd1, 32'sd0);
      for (int i = 0; i < 4; i++) send_word(KIND_READ, PosW'(i), 32'sh1234_5678);
      // read at the length, most negative position, unused kind
      send_word(KIND_READ, 9'sd4, 32'sd0);
      send_word(KIND_READ, 9'sh100, 32'sd0);
      send_word(KindUnused, 9'sd0, 32'sh0f0f_0f0f);
      // erase in the middle and at the end, then out of range
      send_word(KIND_ERASE, 9'sd1, 32'sd0);
      send_word(KIND_ERASE, 9'sd2, 32'sd0);
      send_word(KIND_ERASE, -9'sd1, 32'sd0);
      send_word(KIND_INSERT, 9'sd255, 32'sh5555_5555);
      send_word(KIND_READ, 9'sd0, 32'sd0);
      send_word(KIND_READ, 9'sd1, 32'sd0);
      // drain to empty and erase once more
      send_word(KIND_ERASE, 9'sd0, 32'sd0);
      send_word(KIND_ERASE, 9'sd0, 32'sd0);
      send_word(KIND_ERASE, 9'sd0, 32'sd0);

      // alternate growing and shrinking phases; grow phases reach the full list
      for (int ph = 0; ph < PhaseCount; ph++) begin
         if (ph == 1) long_hold_due = 1'b1;
         repeat (PhaseItems) random_item(ph % 2 == 0);
      end

      // drop valid and wait for the last results
      req_tvalid <= 1'b0;
      while (mirror.outcome_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (mirror.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
